/* hdl/net_bounding_box_wirelength_macros.svh */
// ----------------------------------------------------------------------------
// net bounding box wirelength assertion macros
// shared property wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef NET_BOUNDING_BOX_WIRELENGTH_MACROS_SVH
`define NET_BOUNDING_BOX_WIRELENGTH_MACROS_SVH

`ifndef SYNTHESIS
`define NBBW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nbbw assertion failed");
`define NBBW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nbbw assertion failed");
`else
`define NBBW_ASSERT_IMPL(label, ante, cons)
`define NBBW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hdl/nbbw_pkg.sv */
// ----------------------------------------------------------------------------
// nbbw_pkg
// shared constants, register codes and control structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbbw_pkg;

    localparam int COORD_BITS_DEF      = 32;
    localparam int CELL_INDEX_BITS_DEF = 20;
    localparam int MOVABLE_W           = 21;
    localparam int TOTAL_W             = 48;
    localparam int CFG_IDX_W           = 1;
    localparam int CFG_DATA_W          = 21;
    localparam int DIE_W               = 2;
    localparam int WEIGHT_W            = 2;

    localparam logic [DIE_W-1:0]    DIE_0      = 2'd0;
    localparam logic [DIE_W-1:0]    DIE_1      = 2'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 2'd1;

    // box bound slots
    localparam int BOUNDS = 4;
    localparam int B_XL   = 0;
    localparam int B_XH   = 1;
    localparam int B_YL   = 2;
    localparam int B_YH   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUAL_DIE_MODE = 1'b0,
        REG_MOVABLE_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic feed_a;
        logic feed_b;
        logic dual;
        logic last;
        logic clear;
    } t_pin_ctl;

    typedef struct packed {
        logic a_seen;
        logic b_seen;
        logic dual;
        logic last;
        logic clear;
    } t_box_ctl;

endpackage

/* hdl/nbbw_pin_if.sv */
// ----------------------------------------------------------------------------
// nbbw_pin_if
// pin channel: valid/ready handshake with one pin per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nbbw_pin_if #(
    parameter int COORD_BITS      = nbbw_pkg::COORD_BITS_DEF,
    parameter int CELL_INDEX_BITS = nbbw_pkg::CELL_INDEX_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                pin_valid;
    logic signed [COORD_BITS-1:0]        cell_x;
    logic signed [COORD_BITS-1:0]        cell_y;
    logic signed [COORD_BITS-1:0]        offset_x;
    logic signed [COORD_BITS-1:0]        offset_y;
    logic [nbbw_pkg::DIE_W-1:0]          die_code;
    logic [CELL_INDEX_BITS-1:0]          cell_index;
    logic [nbbw_pkg::WEIGHT_W-1:0]       cell_weight;
    logic                                last_pin;
    logic                                clear_total;

    modport source (
        output valid, pin_valid, cell_x, cell_y, offset_x, offset_y,
               die_code, cell_index, cell_weight, last_pin, clear_total,
        input  ready
    );

    modport sink (
        input  valid, pin_valid, cell_x, cell_y, offset_x, offset_y,
               die_code, cell_index, cell_weight, last_pin, clear_total,
        output ready
    );
endinterface

/* hdl/nbbw_res_if.sv */
// ----------------------------------------------------------------------------
// nbbw_res_if
// result channel: valid/ready handshake with one net result per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nbbw_res_if #(
    parameter int COORD_BITS = nbbw_pkg::COORD_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [COORD_BITS+2:0]            net_wirelength;
    logic [COORD_BITS+1:0]            x_span;
    logic [COORD_BITS+1:0]            y_span;
    logic [nbbw_pkg::TOTAL_W-1:0]     running_total;

    modport source (
        output valid, net_wirelength, x_span, y_span, running_total,
        input  ready
    );

    modport sink (
        input  valid, net_wirelength, x_span, y_span, running_total,
        output ready
    );
endinterface

/* hdl/net_bounding_box_wirelength.sv */
// ----------------------------------------------------------------------------
// net_bounding_box_wirelength
// half-perimeter wirelength of nets streamed one pin per beat
//
// i_pin carries one pin beat (valid/ready); last_pin closes the net and
// o_res returns one beat per closed net: wirelength, x and y spans and the
// saturating running total. config is written through i_cfg_we/i_cfg_idx/
// i_cfg_data; the user must write it only while no beat is in flight;
// the block itself does not enforce this.
// throughput: one pin beat per cycle while o_res does not stall; the box
// compare/update and the running total accumulate are the only loops,
// each a single register. six pipeline stages part i_pin from o_res; a
// stalled o_res fills them and i_pin.ready drops only once all stages
// hold a beat. reset empties both boxes, zeroes the total, selects
// single-die mode and sets movable_count to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module net_bounding_box_wirelength #(
    parameter int COORD_BITS      = nbbw_pkg::COORD_BITS_DEF,
    parameter int CELL_INDEX_BITS = nbbw_pkg::CELL_INDEX_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nbbw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nbbw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    nbbw_pin_if.sink                         i_pin,
    nbbw_res_if.source                       o_res
);

    logic                              r_dual;
    logic [nbbw_pkg::MOVABLE_W-1:0]    r_movable;

    logic                              w_pin_valid;
    logic                              w_pin_ready;
    nbbw_pkg::t_pin_ctl                w_pin_ctl;
    logic signed [COORD_BITS:0]        w_px;
    logic signed [COORD_BITS:0]        w_py;

    logic                              w_box_valid;
    logic                              w_box_ready;
    nbbw_pkg::t_box_ctl                w_box_ctl;
    logic signed [COORD_BITS:0]        w_a [nbbw_pkg::BOUNDS];
    logic signed [COORD_BITS:0]        w_b [nbbw_pkg::BOUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dual    <= 1'b0;
            r_movable <= '0;
        end else if (i_cfg_we) begin
            case (nbbw_pkg::t_cfg_reg'(i_cfg_idx))
                nbbw_pkg::REG_DUAL_DIE_MODE: begin
                    r_dual <= i_cfg_data[0];
                end
                nbbw_pkg::REG_MOVABLE_COUNT: begin
                    r_movable <= i_cfg_data[nbbw_pkg::MOVABLE_W-1:0];
                end
                default: begin
                    r_dual <= r_dual;
                end
            endcase
        end
    end

    nbbw_pin #(
        .COORD_BITS      (COORD_BITS),
        .CELL_INDEX_BITS (CELL_INDEX_BITS)
    ) u_pin (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pin     (i_pin),
        .i_dual    (r_dual),
        .i_movable (r_movable),
        .o_valid   (w_pin_valid),
        .i_ready   (w_pin_ready),
        .o_ctl     (w_pin_ctl),
        .o_px      (w_px),
        .o_py      (w_py)
    );

    nbbw_box #(
        .COORD_BITS (COORD_BITS)
    ) u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pin_valid),
        .o_ready (w_pin_ready),
        .i_ctl   (w_pin_ctl),
        .i_px    (w_px),
        .i_py    (w_py),
        .o_valid (w_box_valid),
        .i_ready (w_box_ready),
        .o_ctl   (w_box_ctl),
        .o_a     (w_a),
        .o_b     (w_b)
    );

    nbbw_hpwl #(
        .COORD_BITS (COORD_BITS)
    ) u_hpwl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_box_valid),
        .o_ready (w_box_ready),
        .i_ctl   (w_box_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_res   (o_res)
    );

endmodule

/* hdl/nbbw_pin.sv */
// ----------------------------------------------------------------------------
// nbbw_pin
// input register, pin point adder and box admission decode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "net_bounding_box_wirelength_macros.svh"

module nbbw_pin #(
    parameter int COORD_BITS      = nbbw_pkg::COORD_BITS_DEF,
    parameter int CELL_INDEX_BITS = nbbw_pkg::CELL_INDEX_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    nbbw_pin_if.sink                            i_pin,
    input  logic                                i_dual,
    input  logic [nbbw_pkg::MOVABLE_W-1:0]      i_movable,
    output logic                                o_valid,
    input  logic                                i_ready,
    output nbbw_pkg::t_pin_ctl                  o_ctl,
    output logic signed [COORD_BITS:0]          o_px,
    output logic signed [COORD_BITS:0]          o_py
);

    localparam int PW    = COORD_BITS + 1;
    localparam int CMP_W = (CELL_INDEX_BITS > nbbw_pkg::MOVABLE_W) ?
                           CELL_INDEX_BITS : nbbw_pkg::MOVABLE_W;

    // input stage
    logic                                r_v0;
    logic                                r_pin_valid;
    logic signed [COORD_BITS-1:0]        r_cx;
    logic signed [COORD_BITS-1:0]        r_cy;
    logic signed [COORD_BITS-1:0]        r_ox;
    logic signed [COORD_BITS-1:0]        r_oy;
    logic [nbbw_pkg::DIE_W-1:0]          r_die;
    logic [CELL_INDEX_BITS-1:0]          r_idx;
    logic [nbbw_pkg::WEIGHT_W-1:0]       r_weight;
    logic                                r_last;
    logic                                r_clear;

    // point stage
    logic                                r_v1;
    nbbw_pkg::t_pin_ctl                  r_s1;
    logic signed [PW-1:0]                r_px;
    logic signed [PW-1:0]                r_py;

    logic                                w_take0;
    logic                                w_take1;
    logic                                w_admit;
    logic signed [PW-1:0]                n_px;
    logic signed [PW-1:0]                n_py;
    nbbw_pkg::t_pin_ctl                  n_s1;

    assign w_take1     = !r_v1 || i_ready;
    assign w_take0     = !r_v0 || w_take1;
    assign i_pin.ready = w_take0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_take0) begin
            r_v0 <= i_pin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take0 && i_pin.valid) begin
            r_pin_valid <= i_pin.pin_valid;
            r_cx        <= i_pin.cell_x;
            r_cy        <= i_pin.cell_y;
            r_ox        <= i_pin.offset_x;
            r_oy        <= i_pin.offset_y;
            r_die       <= i_pin.die_code;
            r_idx       <= i_pin.cell_index;
            r_weight    <= i_pin.cell_weight;
            r_last      <= i_pin.last_pin;
            r_clear     <= i_pin.clear_total;
        end
    end

    always_comb begin
        n_px    = {r_cx[COORD_BITS-1], r_cx} + {r_ox[COORD_BITS-1], r_ox};
        n_py    = {r_cy[COORD_BITS-1], r_cy} + {r_oy[COORD_BITS-1], r_oy};
        w_admit = (CMP_W'(r_idx) < CMP_W'(i_movable)) ||
                  (r_weight == nbbw_pkg::WEIGHT_ONE);
        n_s1.dual  = i_dual;
        n_s1.last  = r_last;
        n_s1.clear = r_clear;
        if (i_dual) begin
            n_s1.feed_a = r_pin_valid && w_admit && (r_die != nbbw_pkg::DIE_1);
            n_s1.feed_b = r_pin_valid && w_admit && (r_die != nbbw_pkg::DIE_0);
        end else begin
            n_s1.feed_a = r_pin_valid && (r_die != nbbw_pkg::DIE_0);
            n_s1.feed_b = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_take1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take1 && r_v0) begin
            r_s1 <= n_s1;
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    assign o_valid = r_v1;
    assign o_ctl   = r_s1;
    assign o_px    = r_px;
    assign o_py    = r_py;

    `NBBW_ASSERT_IMPL(a_single_no_box_b, r_v1 && !r_s1.dual, !r_s1.feed_b)

endmodule

/* hdl/nbbw_box.sv */
// ----------------------------------------------------------------------------
// nbbw_box
// live bounding boxes and a snapshot of them taken on every accepted beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "net_bounding_box_wirelength_macros.svh"

module nbbw_box #(
    parameter int COORD_BITS = nbbw_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  nbbw_pkg::t_pin_ctl          i_ctl,
    input  logic signed [COORD_BITS:0]  i_px,
    input  logic signed [COORD_BITS:0]  i_py,
    output logic                        o_valid,
    input  logic                        i_ready,
    output nbbw_pkg::t_box_ctl          o_ctl,
    output logic signed [COORD_BITS:0]  o_a [nbbw_pkg::BOUNDS],
    output logic signed [COORD_BITS:0]  o_b [nbbw_pkg::BOUNDS]
);

    localparam int PW = COORD_BITS + 1;

    logic signed [PW-1:0]   r_a [nbbw_pkg::BOUNDS];
    logic signed [PW-1:0]   r_b [nbbw_pkg::BOUNDS];
    logic                   r_a_seen;
    logic                   r_b_seen;

    logic                   r_v;
    nbbw_pkg::t_box_ctl     r_ctl;
    logic signed [PW-1:0]   r_sa [nbbw_pkg::BOUNDS];
    logic signed [PW-1:0]   r_sb [nbbw_pkg::BOUNDS];

    logic                   w_take;
    logic                   w_adv;
    logic signed [PW-1:0]   n_a [nbbw_pkg::BOUNDS];
    logic signed [PW-1:0]   n_b [nbbw_pkg::BOUNDS];
    logic                   n_a_seen;
    logic                   n_b_seen;

    function automatic logic signed [PW-1:0] grow_lo(
        input logic signed [PW-1:0] cur,
        input logic signed [PW-1:0] p,
        input logic                 seen
    );
        grow_lo = (!seen || (p < cur)) ? p : cur;
    endfunction

    function automatic logic signed [PW-1:0] grow_hi(
        input logic signed [PW-1:0] cur,
        input logic signed [PW-1:0] p,
        input logic                 seen
    );
        grow_hi = (!seen || (p > cur)) ? p : cur;
    endfunction

    assign w_take  = !r_v || i_ready;
    assign w_adv   = i_valid && w_take;
    assign o_ready = w_take;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        if (i_ctl.feed_a) begin
            n_a[nbbw_pkg::B_XL] = grow_lo(r_a[nbbw_pkg::B_XL], i_px, r_a_seen);
            n_a[nbbw_pkg::B_XH] = grow_hi(r_a[nbbw_pkg::B_XH], i_px, r_a_seen);
            n_a[nbbw_pkg::B_YL] = grow_lo(r_a[nbbw_pkg::B_YL], i_py, r_a_seen);
            n_a[nbbw_pkg::B_YH] = grow_hi(r_a[nbbw_pkg::B_YH], i_py, r_a_seen);
        end
        if (i_ctl.feed_b) begin
            n_b[nbbw_pkg::B_XL] = grow_lo(r_b[nbbw_pkg::B_XL], i_px, r_b_seen);
            n_b[nbbw_pkg::B_XH] = grow_hi(r_b[nbbw_pkg::B_XH], i_px, r_b_seen);
            n_b[nbbw_pkg::B_YL] = grow_lo(r_b[nbbw_pkg::B_YL], i_py, r_b_seen);
            n_b[nbbw_pkg::B_YH] = grow_hi(r_b[nbbw_pkg::B_YH], i_py, r_b_seen);
        end
        n_a_seen = r_a_seen || i_ctl.feed_a;
        n_b_seen = r_b_seen || i_ctl.feed_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_seen <= 1'b0;
            r_b_seen <= 1'b0;
            r_v      <= 1'b0;
        end else begin
            if (w_adv) begin
                r_a_seen <= n_a_seen && !i_ctl.last;
                r_b_seen <= n_b_seen && !i_ctl.last;
            end
            if (w_take) begin
                r_v <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a          <= n_a;
            r_b          <= n_b;
            r_sa         <= n_a;
            r_sb         <= n_b;
            r_ctl.a_seen <= n_a_seen;
            r_ctl.b_seen <= n_b_seen;
            r_ctl.dual   <= i_ctl.dual;
            r_ctl.last   <= i_ctl.last;
            r_ctl.clear  <= i_ctl.clear;
        end
    end

    assign o_valid = r_v;
    assign o_ctl   = r_ctl;
    assign o_a     = r_sa;
    assign o_b     = r_sb;

    `NBBW_ASSERT_IMPL(a_box_a_ordered, r_a_seen, (r_a[nbbw_pkg::B_XL] <= r_a[nbbw_pkg::B_XH]) && (r_a[nbbw_pkg::B_YL] <= r_a[nbbw_pkg::B_YH]))
    `NBBW_ASSERT_NEXT(a_box_empty_after_last, w_adv && i_ctl.last, !r_a_seen && !r_b_seen)

endmodule

/* hdl/nbbw_hpwl.sv */
// ----------------------------------------------------------------------------
// nbbw_hpwl
// span subtract, span sum and result register with saturating total
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "net_bounding_box_wirelength_macros.svh"

module nbbw_hpwl #(
    parameter int COORD_BITS = nbbw_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  nbbw_pkg::t_box_ctl          i_ctl,
    input  logic signed [COORD_BITS:0]  i_a [nbbw_pkg::BOUNDS],
    input  logic signed [COORD_BITS:0]  i_b [nbbw_pkg::BOUNDS],
    nbbw_res_if.source                  o_res
);

    localparam int PW    = COORD_BITS + 1;
    localparam int SW    = COORD_BITS + 2;
    localparam int WW    = COORD_BITS + 3;
    localparam int TW    = nbbw_pkg::TOTAL_W;
    localparam int SUM_W = ((WW > TW) ? WW : TW) + 1;
    localparam logic [TW-1:0] TOTAL_MAX = {TW{1'b1}};

    // span stage
    logic               r_v3;
    logic               r_last3;
    logic               r_clear3;
    logic [PW-1:0]      r_ax;
    logic [PW-1:0]      r_ay;
    logic [PW-1:0]      r_bx;
    logic [PW-1:0]      r_by;

    // sum stage
    logic               r_v4;
    logic               r_last4;
    logic               r_clear4;
    logic [SW-1:0]      r_xs;
    logic [SW-1:0]      r_ys;

    // result stage
    logic               r_ov;
    logic [WW-1:0]      r_wl;
    logic [SW-1:0]      r_oxs;
    logic [SW-1:0]      r_oys;
    logic [TW-1:0]      r_total;

    logic               w_take3;
    logic               w_take4;
    logic               w_take5;
    logic               w_adv5;
    logic               w_use_b;
    logic [PW-1:0]      n_ax;
    logic [PW-1:0]      n_ay;
    logic [PW-1:0]      n_bx;
    logic [PW-1:0]      n_by;
    logic [SUM_W-1:0]   n_sum;
    logic [TW-1:0]      n_total;

    assign w_take5 = !r_ov || o_res.ready;
    assign w_adv5  = r_v4 && w_take5;
    assign w_take4 = !r_v4 || w_take5;
    assign w_take3 = !r_v3 || w_take4;
    assign o_ready = w_take3;

    always_comb begin
        w_use_b = i_ctl.dual && i_ctl.b_seen;
        n_ax = i_ctl.a_seen ? PW'(i_a[nbbw_pkg::B_XH] - i_a[nbbw_pkg::B_XL]) : '0;
        n_ay = i_ctl.a_seen ? PW'(i_a[nbbw_pkg::B_YH] - i_a[nbbw_pkg::B_YL]) : '0;
        n_bx = w_use_b ? PW'(i_b[nbbw_pkg::B_XH] - i_b[nbbw_pkg::B_XL]) : '0;
        n_by = w_use_b ? PW'(i_b[nbbw_pkg::B_YH] - i_b[nbbw_pkg::B_YL]) : '0;
    end

    always_comb begin
        n_sum = (r_clear4 ? '0 : SUM_W'(r_total)) + SUM_W'(r_xs) + SUM_W'(r_ys);
        if (n_sum > SUM_W'(TOTAL_MAX)) begin
            n_total = TOTAL_MAX;
        end else begin
            n_total = n_sum[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_ov    <= 1'b0;
            r_total <= '0;
        end else begin
            if (w_take3) begin
                r_v3 <= i_valid;
            end
            if (w_take4) begin
                r_v4 <= r_v3;
            end
            if (w_take5) begin
                r_ov <= r_v4 && r_last4;
            end
            if (w_adv5) begin
                if (r_last4) begin
                    r_total <= n_total;
                end else if (r_clear4) begin
                    r_total <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take3 && i_valid) begin
            r_last3  <= i_ctl.last;
            r_clear3 <= i_ctl.clear;
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_bx     <= n_bx;
            r_by     <= n_by;
        end
        if (w_take4 && r_v3) begin
            r_last4  <= r_last3;
            r_clear4 <= r_clear3;
            r_xs     <= SW'(r_ax) + SW'(r_bx);
            r_ys     <= SW'(r_ay) + SW'(r_by);
        end
        if (w_adv5 && r_last4) begin
            r_wl  <= WW'(r_xs) + WW'(r_ys);
            r_oxs <= r_xs;
            r_oys <= r_ys;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.net_wirelength = r_wl;
    assign o_res.x_span         = r_oxs;
    assign o_res.y_span         = r_oys;
    assign o_res.running_total  = r_total;

    `NBBW_ASSERT_NEXT(a_total_no_drop, !(w_adv5 && r_clear4), r_total >= $past(r_total))

endmodule
